// ===== hdl/gkw_pkg.sv =====
// Gaussian kernel weight: shared beat types, register indexes and fixed-point constants.
// No dependencies; every other file of the block but gkw_div_pipe imports this package.
package gkw_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_IS_SQUARED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIGMA         = 2'd3;

  // Number of Taylor terms and of exp(-1) multiply stages
  localparam int unsigned TAYLOR_TERMS = 12;
  localparam int unsigned POW_STAGES   = 15;

  typedef struct packed {
    logic [15:0] distance;
    logic [15:0] spread_value;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] weight;
    logic        saturated;
  } out_beat_t;

  // Beat travelling through the Taylor series stages
  typedef struct packed {
    logic [32:0] term;
    logic [33:0] pos;
    logic [33:0] neg;
    logic [15:0] frac;
    logic [3:0]  whole;
    logic        big;
    logic [15:0] sigma;
  } tay_beat_t;

  // Beat leaving the exponent scaling stages
  typedef struct packed {
    logic [33:0] num;
    logic [23:0] den;
    logic [16:0] plain;
  } scale_beat_t;

  // exp(-1.0) in Q0.32, built with the same rounded series as the datapath
  localparam logic [63:0] E1T0  = 64'h1_0000_0000;
  localparam logic [63:0] E1T1  = (E1T0  * 64'd65536 + 64'd1  * 64'd32768) / (64'd1  * 64'd65536);
  localparam logic [63:0] E1T2  = (E1T1  * 64'd65536 + 64'd2  * 64'd32768) / (64'd2  * 64'd65536);
  localparam logic [63:0] E1T3  = (E1T2  * 64'd65536 + 64'd3  * 64'd32768) / (64'd3  * 64'd65536);
  localparam logic [63:0] E1T4  = (E1T3  * 64'd65536 + 64'd4  * 64'd32768) / (64'd4  * 64'd65536);
  localparam logic [63:0] E1T5  = (E1T4  * 64'd65536 + 64'd5  * 64'd32768) / (64'd5  * 64'd65536);
  localparam logic [63:0] E1T6  = (E1T5  * 64'd65536 + 64'd6  * 64'd32768) / (64'd6  * 64'd65536);
  localparam logic [63:0] E1T7  = (E1T6  * 64'd65536 + 64'd7  * 64'd32768) / (64'd7  * 64'd65536);
  localparam logic [63:0] E1T8  = (E1T7  * 64'd65536 + 64'd8  * 64'd32768) / (64'd8  * 64'd65536);
  localparam logic [63:0] E1T9  = (E1T8  * 64'd65536 + 64'd9  * 64'd32768) / (64'd9  * 64'd65536);
  localparam logic [63:0] E1T10 = (E1T9  * 64'd65536 + 64'd10 * 64'd32768) / (64'd10 * 64'd65536);
  localparam logic [63:0] E1T11 = (E1T10 * 64'd65536 + 64'd11 * 64'd32768) / (64'd11 * 64'd65536);
  localparam logic [63:0] E1T12 = (E1T11 * 64'd65536 + 64'd12 * 64'd32768) / (64'd12 * 64'd65536);
  localparam logic [63:0] E1_POS = E1T0 + E1T2 + E1T4 + E1T6 + E1T8 + E1T10 + E1T12;
  localparam logic [63:0] E1_NEG = E1T1 + E1T3 + E1T5 + E1T7 + E1T9 + E1T11;
  localparam logic [31:0] EXP_NEG_ONE = 32'(E1_POS - E1_NEG);

  // Powers of 1/sqrt(2*pi) in Q0.32, each step rounded
  localparam logic [63:0] NORM_C  = 64'd1713444047;
  localparam logic [63:0] NORM_K1 = NORM_C;
  localparam logic [63:0] NORM_K2 = (NORM_K1 * NORM_C + 64'h8000_0000) >> 32;
  localparam logic [63:0] NORM_K3 = (NORM_K2 * NORM_C + 64'h8000_0000) >> 32;
  localparam logic [63:0] NORM_K4 = (NORM_K3 * NORM_C + 64'h8000_0000) >> 32;
  localparam logic [63:0] NORM_K5 = (NORM_K4 * NORM_C + 64'h8000_0000) >> 32;
  localparam logic [63:0] NORM_K6 = (NORM_K5 * NORM_C + 64'h8000_0000) >> 32;
  localparam logic [63:0] NORM_K7 = (NORM_K6 * NORM_C + 64'h8000_0000) >> 32;
  localparam logic [63:0] NORM_K8 = (NORM_K7 * NORM_C + 64'h8000_0000) >> 32;

  // Normalization constant; dimension 0 acts as 1, above eight acts as eight
  function automatic logic [31:0] norm_const(input logic [3:0] dim);
    logic [31:0] k;
    unique case (dim) inside
      4'd0, 4'd1: k = NORM_K1[31:0];
      4'd2:       k = NORM_K2[31:0];
      4'd3:       k = NORM_K3[31:0];
      4'd4:       k = NORM_K4[31:0];
      4'd5:       k = NORM_K5[31:0];
      4'd6:       k = NORM_K6[31:0];
      4'd7:       k = NORM_K7[31:0];
      default:    k = NORM_K8[31:0];
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/gkw_div_pipe.sv =====
// Pipelined restoring divider, a fixed number of quotient bits per stage.
// Depends on nothing; the caller guarantees num < den << Q_W for a valid quotient.
module gkw_div_pipe #(
  parameter int unsigned NUM_W  = 49,
  parameter int unsigned DEN_W  = 33,
  parameter int unsigned Q_W    = 20,
  parameter int unsigned SIDE_W = 17,
  parameter int unsigned BPS    = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned NSTG = Q_W / BPS;
  localparam int unsigned WW   = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [NSTG-1:0]   valid_q;
  logic [Q_W-1:0]    quo_q  [NSTG];
  logic [SIDE_W-1:0] side_q [NSTG];
  logic [WW-1:0]     rem_q  [NSTG-1];
  logic [DEN_W-1:0]  den_q  [NSTG-1];

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    logic [WW-1:0]     rem_in, rem_nx;
    logic [DEN_W-1:0]  den_in;
    logic [Q_W-1:0]    quo_in, quo_nx;
    logic [SIDE_W-1:0] side_in;
    logic              vin;

    if (g == 0) begin : g_first
      assign rem_in  = WW'(num_i);
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vin     = valid_i;
    end else begin : g_rest
      assign rem_in  = rem_q[g-1];
      assign den_in  = den_q[g-1];
      assign quo_in  = quo_q[g-1];
      assign side_in = side_q[g-1];
      assign vin     = valid_q[g-1];
    end

    // BPS compare-and-subtract steps, most significant quotient bit first
    always_comb begin
      logic [WW-1:0] cand;
      int            sh;
      rem_nx = rem_in;
      quo_nx = quo_in;
      for (int b = 0; b < BPS; b++) begin
        sh   = Q_W - 1 - g * BPS - b;
        cand = WW'(den_in) << sh;
        if (rem_nx >= cand) begin
          rem_nx = rem_nx - cand;
          quo_nx = quo_nx | (Q_W'(1) << sh);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[g]  <= quo_nx;
        side_q[g] <= side_in;
      end
    end

    if (g < NSTG - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[g] <= rem_nx;
          den_q[g] <= den_in;
        end
      end
    end
  end

  assign valid_o = valid_q[NSTG-1];
  assign quo_o   = quo_q[NSTG-1];
  assign side_o  = side_q[NSTG-1];

endmodule

// ===== hdl/gkw_taylor_step.sv =====
// One term of the exp(-f) Taylor series: multiply by f, round, divide by the term index.
// Depends on gkw_pkg (tay_beat_t); four register stages.
module gkw_taylor_step
  import gkw_pkg::*;
#(
  parameter int unsigned K = 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  tay_beat_t beat_i,
  output logic      valid_o,
  output tay_beat_t beat_o
);

  // floor(2^35 / K) gives a quotient estimate that is low by at most one
  localparam logic [35:0] RECIP    = 36'((64'd1 << 35) / K);
  localparam logic [49:0] RND      = 50'(K) << 15;
  localparam logic [3:0]  KV       = 4'(K);
  localparam bit          ODD_TERM = (K % 2) == 1;

  logic        s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  tay_beat_t   s1_b_q, s2_b_q, s3_b_q, s4_b_q;
  logic [48:0] s1_prod_q;
  logic [33:0] s2_n_q, s3_n_q, s3_q0_q;
  logic [52:0] s2_pl_q, s2_ph_q;

  logic [33:0] n_d;
  logic [70:0] full_d;
  logic [37:0] qk_d, r_d;
  logic [33:0] q_d;
  tay_beat_t   nb_d;

  // Stage 2: round and shift, reciprocal partial products
  assign n_d = 34'((50'(s1_prod_q) + RND) >> 16);

  // Stage 3: reciprocal product, quotient estimate
  assign full_d = (71'(s2_ph_q) << 17) + 71'(s2_pl_q);

  // Stage 4: one correction step, then accumulate by sign
  assign qk_d = 38'(s3_q0_q) * 38'(KV);
  assign r_d  = 38'(s3_n_q) - qk_d;
  assign q_d  = (r_d >= 38'(KV)) ? s3_q0_q + 34'd1 : s3_q0_q;

  always_comb begin
    nb_d      = s3_b_q;
    nb_d.term = q_d[32:0];
    if (ODD_TERM) begin
      nb_d.neg = s3_b_q.neg + 34'(q_d[32:0]);
    end else begin
      nb_d.pos = s3_b_q.pos + 34'(q_d[32:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_b_q    <= beat_i;
      s1_prod_q <= 49'(beat_i.term) * 49'(beat_i.frac);
      s2_b_q    <= s1_b_q;
      s2_n_q    <= n_d;
      s2_pl_q   <= 53'(n_d[16:0]) * 53'(RECIP);
      s2_ph_q   <= 53'(n_d[33:17]) * 53'(RECIP);
      s3_b_q    <= s2_b_q;
      s3_n_q    <= s2_n_q;
      s3_q0_q   <= 34'(full_d >> 35);
      s4_b_q    <= nb_d;
    end
  end

  assign valid_o = s4_v_q;
  assign beat_o  = s4_b_q;

endmodule

// ===== hdl/gkw_exp_scale.sv =====
// Finishes exp(-x): series result times exp(-1) once per whole unit of x, then the
// normalization product and the divider operands. Depends on gkw_pkg.
module gkw_exp_scale
  import gkw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  tay_beat_t   beat_i,
  input  logic [3:0]  dim_i,
  output logic        valid_o,
  output scale_beat_t beat_o
);

  logic        e0_v_q;
  logic [32:0] e0_q;
  logic [3:0]  e0_whole_q;
  logic [15:0] e0_sig_q;
  logic [32:0] e0_d;

  logic [POW_STAGES-1:0] pv_q, app_q;
  logic [64:0] prod_q  [POW_STAGES];
  logic [32:0] eprev_q [POW_STAGES];
  logic [3:0]  whole_q [POW_STAGES];
  logic [15:0] sig_q   [POW_STAGES];
  logic [32:0] e_out   [POW_STAGES];

  logic        n1_v_q, n2_v_q;
  logic [64:0] n1_kp_q;
  logic [16:0] n1_plain_q;
  logic [15:0] n1_sig_q;
  logic [32:0] e_fin;
  logic [64:0] p_sum;
  scale_beat_t n2_d, n2_q;

  // Series result; x of 16.0 or more gives zero
  always_comb begin
    if (beat_i.big || (beat_i.neg > beat_i.pos)) begin
      e0_d = '0;
    end else begin
      e0_d = 33'(beat_i.pos - beat_i.neg);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_v_q <= 1'b0;
    end else if (en_i) begin
      e0_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e0_q       <= e0_d;
      e0_whole_q <= beat_i.whole;
      e0_sig_q   <= beat_i.sigma;
    end
  end

  // exp(-1) multiply chain; stage p applies when the whole part exceeds p
  for (genvar p = 0; p < POW_STAGES; p++) begin : g_pow
    logic [32:0] e_in;
    logic [3:0]  w_in;
    logic [15:0] s_in;
    logic        v_in;
    logic [64:0] rnd;

    if (p == 0) begin : g_first
      assign e_in = e0_q;
      assign w_in = e0_whole_q;
      assign s_in = e0_sig_q;
      assign v_in = e0_v_q;
    end else begin : g_rest
      assign e_in = e_out[p-1];
      assign w_in = whole_q[p-1];
      assign s_in = sig_q[p-1];
      assign v_in = pv_q[p-1];
    end

    assign rnd      = prod_q[p] + 65'h8000_0000;
    assign e_out[p] = app_q[p] ? rnd[64:32] : eprev_q[p];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[p] <= 1'b0;
      end else if (en_i) begin
        pv_q[p] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q[p]  <= 65'(e_in) * 65'(EXP_NEG_ONE);
        eprev_q[p] <= e_in;
        app_q[p]   <= (w_in >= 4'(p + 1));
        whole_q[p] <= w_in;
        sig_q[p]   <= s_in;
      end
    end
  end

  assign e_fin = e_out[POW_STAGES-1];

  // Normalization product, rounded plain weight
  assign p_sum = n1_kp_q + 65'h8000_0000;

  always_comb begin
    n2_d.num   = 34'(p_sum[64:32]) + 34'({n1_sig_q, 7'b0});
    n2_d.den   = {n1_sig_q, 8'b0};
    n2_d.plain = n1_plain_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_v_q <= 1'b0;
      n2_v_q <= 1'b0;
    end else if (en_i) begin
      n1_v_q <= pv_q[POW_STAGES-1];
      n2_v_q <= n1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_kp_q    <= 65'(e_fin) * 65'(norm_const(dim_i));
      n1_plain_q <= 17'((34'(e_fin) + 34'h8000) >> 16);
      n1_sig_q   <= sig_q[POW_STAGES-1];
      n2_q       <= n2_d;
    end
  end

  assign valid_o = n2_v_q;
  assign beat_o  = n2_q;

endmodule

// ===== hdl/gaussian_kernel_weight_core.sv =====
// Gaussian kernel weight top level: config registers, front end, pipeline glue, output stage.
// Depends on gkw_pkg, gkw_div_pipe, gkw_taylor_step and gkw_exp_scale.
//
// Computes exp(-d^2 / (2*sigma^2)) per beat, optionally divided by (2*pi)^(dim/2)*sigma,
// from unsigned Q8.8 inputs to an unsigned Q16.16 weight. The block takes one beat every
// clock unless stalled, through 4 front-end stages, a 10-stage divider for the exponent,
// 48 stages of Taylor series (four per term), 18 stages of exp(-1) multiplies and
// normalization, a 13-stage divider for the normalized weight and the output register. The
// whole pipeline advances together; it holds while a result in the output register is
// stalled. The user writes configuration only while no beat is in flight; it is not enforced.
module gaussian_kernel_weight_core
  import gkw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_beat_t             in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_beat_t            out_beat_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);

  logic        normalize_mode_q, spread_is_squared_q;
  logic [3:0]  dimension_q;
  logic [15:0] min_sigma_q;

  logic        adv;
  logic        out_valid_q;
  out_beat_t   out_q, out_d;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normalize_mode_q    <= 1'b0;
      spread_is_squared_q <= 1'b0;
      dimension_q         <= 4'd1;
      min_sigma_q         <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NORMALIZE_MODE:    normalize_mode_q    <= cfg_data_i[0];
        CFG_SPREAD_IS_SQUARED: spread_is_squared_q <= cfg_data_i[0];
        CFG_DIMENSION:         dimension_q         <= cfg_data_i[3:0];
        CFG_MIN_SIGMA:         min_sigma_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Whole pipeline moves when the output register is free or being taken
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Front end, stage 1: clamp sigma
  logic        f1_v_q, f2_v_q, f3_v_q, f4_v_q;
  logic [15:0] f1_d_q, f1_s_q, f1_sig_q, f1_m_q;
  logic [15:0] m_d, sig_d;

  assign m_d   = (min_sigma_q == '0) ? 16'd1 : min_sigma_q;
  assign sig_d = (in_beat_i.spread_value < m_d) ? m_d : in_beat_i.spread_value;

  // Stage 2: squares
  logic [31:0] f2_dd_q, f2_ss_q, f2_mm_q;
  logic [15:0] f2_s_q, f2_sig_q;

  // Stage 3: squared spread, dividend and divisor of the exponent
  logic [23:0] s_sh;
  logic [31:0] sq_sig2, sig2;
  logic [48:0] f3_num_q;
  logic [32:0] f3_den_q;
  logic [15:0] f3_sig_q;

  assign s_sh    = {f2_s_q, 8'b0};
  assign sq_sig2 = (32'(s_sh) < f2_mm_q) ? f2_mm_q : 32'(s_sh);
  assign sig2    = (!normalize_mode_q && spread_is_squared_q) ? sq_sig2 : f2_ss_q;

  // Stage 4: exponent of 16.0 or more flushes the weight to zero
  logic [48:0] f4_num_q;
  logic [32:0] f4_den_q;
  logic [15:0] f4_sig_q;
  logic        f4_big_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
      f4_v_q <= 1'b0;
    end else if (adv) begin
      f1_v_q <= in_valid_i;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
      f4_v_q <= f3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_d_q   <= in_beat_i.distance;
      f1_s_q   <= in_beat_i.spread_value;
      f1_sig_q <= sig_d;
      f1_m_q   <= m_d;
      f2_dd_q  <= 32'(f1_d_q) * 32'(f1_d_q);
      f2_ss_q  <= 32'(f1_sig_q) * 32'(f1_sig_q);
      f2_mm_q  <= 32'(f1_m_q) * 32'(f1_m_q);
      f2_s_q   <= f1_s_q;
      f2_sig_q <= f1_sig_q;
      f3_num_q <= {1'b0, f2_dd_q, 16'b0} + 49'(sig2);
      f3_den_q <= {sig2, 1'b0};
      f3_sig_q <= f2_sig_q;
      f4_num_q <= f3_num_q;
      f4_den_q <= f3_den_q;
      f4_sig_q <= f3_sig_q;
      f4_big_q <= {4'b0, f3_num_q} >= {f3_den_q, 20'b0};
    end
  end

  // Exponent x = round(d^2 / (2*sigma^2)) in Q4.16
  logic        d1_v;
  logic [19:0] d1_x;
  logic [16:0] d1_side;

  gkw_div_pipe #(
    .NUM_W (49),
    .DEN_W (33),
    .Q_W   (20),
    .SIDE_W(17),
    .BPS   (2)
  ) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(f4_v_q),
    .num_i  (f4_num_q),
    .den_i  (f4_den_q),
    .side_i ({f4_big_q, f4_sig_q}),
    .valid_o(d1_v),
    .quo_o  (d1_x),
    .side_o (d1_side)
  );

  // Taylor series of exp(-frac(x))
  logic      tay_v [TAYLOR_TERMS+1];
  tay_beat_t tay_b [TAYLOR_TERMS+1];

  always_comb begin
    tay_b[0].term  = 33'h1_0000_0000;
    tay_b[0].pos   = 34'h1_0000_0000;
    tay_b[0].neg   = '0;
    tay_b[0].frac  = d1_x[15:0];
    tay_b[0].whole = d1_x[19:16];
    tay_b[0].big   = d1_side[16];
    tay_b[0].sigma = d1_side[15:0];
  end
  assign tay_v[0] = d1_v;

  for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_term
    gkw_taylor_step #(
      .K(k)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(tay_v[k-1]),
      .beat_i (tay_b[k-1]),
      .valid_o(tay_v[k]),
      .beat_o (tay_b[k])
    );
  end

  // Whole-part scaling and normalization
  logic        sc_v;
  scale_beat_t sc_b;

  gkw_exp_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(tay_v[TAYLOR_TERMS]),
    .beat_i (tay_b[TAYLOR_TERMS]),
    .dim_i  (dimension_q),
    .valid_o(sc_v),
    .beat_o (sc_b)
  );

  // Normalized weight = round(P / (256*sigma))
  logic        d2_v;
  logic [25:0] d2_q;
  logic [16:0] d2_plain;

  gkw_div_pipe #(
    .NUM_W (34),
    .DEN_W (24),
    .Q_W   (26),
    .SIDE_W(17),
    .BPS   (2)
  ) u_div_w (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(sc_v),
    .num_i  (sc_b.num),
    .den_i  (sc_b.den),
    .side_i (sc_b.plain),
    .valid_o(d2_v),
    .quo_o  (d2_q),
    .side_o (d2_plain)
  );

  // Output select and clip
  logic [32:0] w_wide;

  assign w_wide = normalize_mode_q ? 33'(d2_q) : 33'(d2_plain);

  always_comb begin
    out_d.saturated = w_wide[32];
    out_d.weight    = w_wide[32] ? '1 : w_wide[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= d2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

// ===== hdl/gkw_checker.sv =====
// Port-level checks for gaussian_kernel_weight_core and the bind that attaches them.
// Depends on gkw_pkg and the top level's ports.
module gkw_port_assert
  import gkw_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_beat_o
);

  // A stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // A stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_beat_o))
    else $error("output payload changed while stalled");

  // Input is held off only by a stalled result
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // The clip flag goes with a full-scale weight
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.saturated |-> out_beat_o.weight == 32'hFFFF_FFFF)
    else $error("saturated flag without full-scale weight");

endmodule

bind gaussian_kernel_weight_core gkw_port_assert u_gkw_port_assert (.*);
